### hw/rtl/snbd_pkg.sv
// Shared types, constants and sizes for the Snappy block decompressor.
// Used by every module under hw/rtl except snbd_chk; depends on nothing else.
package snbd_pkg;

    // History depth is a power of two so that pointers wrap by truncation.
    localparam int HISTORY_DEPTH = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int HELD_W        = HIST_AW + 1;
    localparam int ACC_W         = 32;
    localparam int ALU_W         = ACC_W + 1;
    localparam int LEN_W         = 7;

    localparam int LIT_INLINE_MAX = 60;
    localparam int LIT_HDR_BIAS   = 59;
    localparam int COPY1_BASE     = 4;
    localparam int COPY2_OFF_LEN  = 2;
    localparam int COPY4_OFF_LEN  = 4;

    typedef enum logic [1:0] {
        ELEM_LITERAL = 2'd0,
        ELEM_COPY1   = 2'd1,
        ELEM_COPY2   = 2'd2,
        ELEM_COPY4   = 2'd3
    } elem_t;

    typedef enum logic [1:0] {
        PH_TAG     = 2'd0,
        PH_LITLEN  = 2'd1,
        PH_LITDATA = 2'd2,
        PH_COPYOFF = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_LIT     = 3'd1,
        S_CHECK   = 3'd2,
        S_ERR     = 3'd3,
        S_ADDR    = 3'd4,
        S_COPY_RD = 3'd5,
        S_COPY_WR = 3'd6
    } state_t;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } hist_req_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       last;
        logic       err;
    } emit_t;

endpackage

### hw/rtl/snbd_alu.sv
// Shared subtract-and-compare unit of the decompressor sequencer.
// Depends on snbd_pkg for its width.
module snbd_alu (
    input  logic [snbd_pkg::ALU_W-1:0] a,
    input  logic [snbd_pkg::ALU_W-1:0] b,
    output logic [snbd_pkg::ALU_W-1:0] diff,
    output logic                       borrow
);

    logic [snbd_pkg::ALU_W:0] full;

    // The extra top bit is set exactly when b exceeds a.
    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[snbd_pkg::ALU_W-1:0];
    assign borrow = full[snbd_pkg::ALU_W];

endmodule

### hw/rtl/snbd_hist.sv
// History store of decoded bytes: one write port, one registered read port.
// Depends on snbd_pkg for the depth and the request struct.
module snbd_hist (
    input  logic                  clk,
    input  snbd_pkg::hist_req_t   req,
    output logic [7:0]            rdata
);

    logic [7:0] mem [snbd_pkg::HISTORY_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/snbd_ctrl.sv
// Tag parser and sequencer: decodes elements, drives the history store and
// the shared subtract unit. Depends on snbd_pkg and snbd_alu.
module snbd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  stream_start,
    output logic                  in_ready,
    input  logic                  slot_free,
    output snbd_pkg::emit_t       emit,
    output snbd_pkg::hist_req_t   hist_req,
    input  logic [7:0]            hist_rdata
);

    snbd_pkg::state_t                state_reg, state_next;
    snbd_pkg::phase_t                phase_reg, phase_next;
    logic [2:0]                      hdr_left_reg, hdr_left_next;
    logic [1:0]                      seen_reg, seen_next;
    logic [snbd_pkg::ALU_W-1:0]      lit_left_reg, lit_left_next;
    logic [snbd_pkg::LEN_W-1:0]      copy_len_reg, copy_len_next;
    logic [snbd_pkg::LEN_W-1:0]      copy_left_reg, copy_left_next;
    logic [snbd_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [snbd_pkg::HIST_AW-1:0]    wp_reg, wp_next;
    logic [snbd_pkg::HIST_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [snbd_pkg::HELD_W-1:0]     held_reg, held_next;
    logic [7:0]                      byte_reg, byte_next;

    logic                            in_go;
    snbd_pkg::phase_t                eff_phase;
    logic [5:0]                      tag_val;
    logic [snbd_pkg::ACC_W-1:0]      acc_merged;
    logic [snbd_pkg::ALU_W-1:0]      alu_a, alu_b, alu_diff;
    logic                            alu_borrow;
    logic                            hist_put;
    logic [snbd_pkg::HELD_W-1:0]     held_inc;

    snbd_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    assign in_go     = in_valid && in_ready;
    // A stream start clears the parser before this byte, so it is a tag.
    assign eff_phase = stream_start ? snbd_pkg::PH_TAG : phase_reg;
    assign tag_val   = in_byte[7:2];
    assign acc_merged = acc_reg
        | ({{(snbd_pkg::ACC_W-8){1'b0}}, in_byte} << {seen_reg, 3'b000});
    assign held_inc = (held_reg == snbd_pkg::HELD_W'(snbd_pkg::HISTORY_DEPTH))
        ? held_reg : held_reg + 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            snbd_pkg::S_IDLE:
            begin
                if (in_go)
                begin
                    if (eff_phase == snbd_pkg::PH_LITDATA)
                    begin
                        state_next = snbd_pkg::S_LIT;
                    end
                    else if (eff_phase == snbd_pkg::PH_COPYOFF && hdr_left_reg == 3'd1)
                    begin
                        state_next = snbd_pkg::S_CHECK;
                    end
                end
            end
            snbd_pkg::S_LIT:
            begin
                if (slot_free)
                begin
                    state_next = snbd_pkg::S_IDLE;
                end
            end
            snbd_pkg::S_CHECK:
            begin
                if (acc_reg == '0 || alu_borrow)
                begin
                    state_next = snbd_pkg::S_ERR;
                end
                else
                begin
                    state_next = snbd_pkg::S_ADDR;
                end
            end
            snbd_pkg::S_ERR:
            begin
                if (slot_free)
                begin
                    state_next = snbd_pkg::S_IDLE;
                end
            end
            snbd_pkg::S_ADDR:
            begin
                state_next = snbd_pkg::S_COPY_RD;
            end
            snbd_pkg::S_COPY_RD:
            begin
                state_next = snbd_pkg::S_COPY_WR;
            end
            snbd_pkg::S_COPY_WR:
            begin
                if (slot_free)
                begin
                    state_next = (copy_left_reg == snbd_pkg::LEN_W'(1))
                        ? snbd_pkg::S_IDLE : snbd_pkg::S_COPY_RD;
                end
            end
            default:
            begin
                state_next = snbd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: handshake, result, history port and shared-unit operands.
    always_comb
    begin
        in_ready = 1'b0;
        emit     = '0;
        hist_put = 1'b0;
        hist_req = '0;
        alu_a    = '0;
        alu_b    = '0;
        case (state_reg)
            snbd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            snbd_pkg::S_LIT:
            begin
                alu_a = lit_left_reg;
                alu_b = snbd_pkg::ALU_W'(1);
                if (slot_free)
                begin
                    emit.vld  = 1'b1;
                    emit.data = byte_reg;
                    emit.last = 1'b1;
                    hist_put  = 1'b1;
                end
            end
            snbd_pkg::S_CHECK:
            begin
                alu_a = snbd_pkg::ALU_W'(held_reg);
                alu_b = snbd_pkg::ALU_W'(acc_reg);
            end
            snbd_pkg::S_ERR:
            begin
                if (slot_free)
                begin
                    emit.vld  = 1'b1;
                    emit.last = 1'b1;
                    emit.err  = 1'b1;
                end
            end
            snbd_pkg::S_ADDR:
            begin
                alu_a = snbd_pkg::ALU_W'(wp_reg);
                alu_b = snbd_pkg::ALU_W'(acc_reg);
            end
            snbd_pkg::S_COPY_RD:
            begin
                hist_req.re    = 1'b1;
                hist_req.raddr = rd_ptr_reg;
            end
            snbd_pkg::S_COPY_WR:
            begin
                if (slot_free)
                begin
                    emit.vld  = 1'b1;
                    emit.data = hist_rdata;
                    emit.last = (copy_left_reg == snbd_pkg::LEN_W'(1));
                    hist_put  = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        hist_req.we    = hist_put;
        hist_req.waddr = wp_reg;
        hist_req.wdata = emit.data;
    end

    // Datapath next values.
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_left_next  = hdr_left_reg;
        seen_next      = seen_reg;
        lit_left_next  = lit_left_reg;
        copy_len_next  = copy_len_reg;
        copy_left_next = copy_left_reg;
        acc_next       = acc_reg;
        wp_next        = wp_reg;
        rd_ptr_next    = rd_ptr_reg;
        held_next      = held_reg;
        byte_next      = byte_reg;

        if (hist_put)
        begin
            wp_next   = wp_reg + 1'b1;
            held_next = held_inc;
        end

        case (state_reg)
            snbd_pkg::S_IDLE:
            begin
                if (in_go)
                begin
                    if (stream_start)
                    begin
                        wp_next   = '0;
                        held_next = '0;
                    end
                    case (eff_phase)
                        snbd_pkg::PH_LITLEN:
                        begin
                            acc_next      = acc_merged;
                            seen_next     = seen_reg + 1'b1;
                            hdr_left_next = hdr_left_reg - 1'b1;
                            if (hdr_left_reg == 3'd1)
                            begin
                                lit_left_next = {1'b0, acc_merged} + 1'b1;
                                phase_next    = snbd_pkg::PH_LITDATA;
                            end
                        end
                        snbd_pkg::PH_LITDATA:
                        begin
                            byte_next = in_byte;
                        end
                        snbd_pkg::PH_COPYOFF:
                        begin
                            acc_next      = acc_merged;
                            seen_next     = seen_reg + 1'b1;
                            hdr_left_next = hdr_left_reg - 1'b1;
                        end
                        default:
                        begin
                            acc_next  = '0;
                            seen_next = '0;
                            case (snbd_pkg::elem_t'(in_byte[1:0]))
                                snbd_pkg::ELEM_LITERAL:
                                begin
                                    if (tag_val < 6'(snbd_pkg::LIT_INLINE_MAX))
                                    begin
                                        lit_left_next = snbd_pkg::ALU_W'(tag_val) + 1'b1;
                                        phase_next    = snbd_pkg::PH_LITDATA;
                                    end
                                    else
                                    begin
                                        hdr_left_next =
                                            3'(tag_val - 6'(snbd_pkg::LIT_HDR_BIAS));
                                        phase_next    = snbd_pkg::PH_LITLEN;
                                    end
                                end
                                snbd_pkg::ELEM_COPY1:
                                begin
                                    copy_len_next = snbd_pkg::LEN_W'(in_byte[4:2])
                                        + snbd_pkg::LEN_W'(snbd_pkg::COPY1_BASE);
                                    acc_next      = {21'd0, in_byte[7:5], 8'd0};
                                    hdr_left_next = 3'd1;
                                    phase_next    = snbd_pkg::PH_COPYOFF;
                                end
                                snbd_pkg::ELEM_COPY2:
                                begin
                                    copy_len_next = snbd_pkg::LEN_W'(tag_val) + 1'b1;
                                    hdr_left_next = 3'(snbd_pkg::COPY2_OFF_LEN);
                                    phase_next    = snbd_pkg::PH_COPYOFF;
                                end
                                default:
                                begin
                                    copy_len_next = snbd_pkg::LEN_W'(tag_val) + 1'b1;
                                    hdr_left_next = 3'(snbd_pkg::COPY4_OFF_LEN);
                                    phase_next    = snbd_pkg::PH_COPYOFF;
                                end
                            endcase
                        end
                    endcase
                end
            end
            snbd_pkg::S_LIT:
            begin
                if (slot_free)
                begin
                    lit_left_next = alu_diff;
                    if (alu_diff == '0)
                    begin
                        phase_next = snbd_pkg::PH_TAG;
                    end
                end
            end
            snbd_pkg::S_CHECK:
            begin
                phase_next = snbd_pkg::PH_TAG;
            end
            snbd_pkg::S_ADDR:
            begin
                // Pointer arithmetic wraps with the power-of-two depth.
                rd_ptr_next    = alu_diff[snbd_pkg::HIST_AW-1:0];
                copy_left_next = copy_len_reg;
            end
            snbd_pkg::S_COPY_WR:
            begin
                if (slot_free)
                begin
                    rd_ptr_next    = rd_ptr_reg + 1'b1;
                    copy_left_next = copy_left_reg - 1'b1;
                end
            end
            default:
            begin
                byte_next = byte_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snbd_pkg::S_IDLE;
            phase_reg     <= snbd_pkg::PH_TAG;
            hdr_left_reg  <= '0;
            seen_reg      <= '0;
            lit_left_reg  <= '0;
            copy_len_reg  <= '0;
            copy_left_reg <= '0;
            acc_reg       <= '0;
            wp_reg        <= '0;
            held_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            hdr_left_reg  <= hdr_left_next;
            seen_reg      <= seen_next;
            lit_left_reg  <= lit_left_next;
            copy_len_reg  <= copy_len_next;
            copy_left_reg <= copy_left_next;
            acc_reg       <= acc_next;
            wp_reg        <= wp_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        byte_reg   <= byte_next;
    end

endmodule

### hw/rtl/snappy_block_decompressor.sv
// Top level of the Snappy block decompressor: sequencer, history store and
// output register. Depends on snbd_pkg, snbd_ctrl and snbd_hist.
//
//  Channel  Direction  Signals                      Contents
//  s_axis   in         tvalid tready tdata tuser    compressed body bytes
//  m_axis   out        tvalid tready tdata tlast    decoded bytes, error flag
//                      tuser
//
// Tag and header bytes are taken in the idle state; a literal data byte then
// passes through the literal state to be emitted. The transfer carrying the
// last offset byte of a copy holds the block through check and address, then
// a registered history read and a write per byte, so that an overlapping copy
// sees its own bytes. A bad offset leads from the check to one error result.
// Output stalls hold the sequencer; one finished result waits in the output
// register. Reset clears control state only; the history store needs no sweep.
module snappy_block_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0] s_axis_tuser,   // [0] stream_start
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser    // [0] error
);

    snbd_pkg::emit_t     emit;
    snbd_pkg::hist_req_t hist_req;
    logic [7:0]          hist_rdata;
    logic                slot_free;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                out_err_reg, out_err_next;

    assign slot_free = !out_valid_reg || m_axis_tready;

    snbd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_byte      (s_axis_tdata),
        .stream_start (s_axis_tuser[0]),
        .in_ready     (s_axis_tready),
        .slot_free    (slot_free),
        .emit         (emit),
        .hist_req     (hist_req),
        .hist_rdata   (hist_rdata)
    );

    snbd_hist u_hist (
        .clk   (clk),
        .req   (hist_req),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (emit.vld)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit.data;
            out_last_next  = emit.last;
            out_err_next   = emit.err;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

### hw/rtl/snbd_chk.sv
// Port-level checker for the Snappy block decompressor, bound to the top.
// Depends only on the top level's ports.
module snbd_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [0:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [0:0] m_axis_tuser
);

    // A stalled result must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // An error result is a single zero byte closing its transfer.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && m_axis_tlast)
        else $error("malformed error result");

    // Mid-copy results keep the input side closed.
    a_copy_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open during a copy");

    // The block leaves reset ready for input with no result pending.
    a_reset_ready: assert property (@(posedge clk)
        $rose(rst_n) |-> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

endmodule

bind snappy_block_decompressor snbd_chk u_snbd_chk (.*);

### tb/sv/snbd_decode_checker.sv
`timescale 1ns / 100ps
// Checker for the Snappy block decompressor: watches both stream channels, decodes
// each accepted compressed byte itself and compares every decoded byte that comes out.
// Depends on snbd_pkg for the element and parse phase codes and the history sizes.
module snbd_decode_checker
    import snbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0] s_axis_tuser,   // [0] stream_start
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic       m_axis_tlast,
    input  logic [0:0] m_axis_tuser,   // [0] error
    output int         fail_count,
    output int         bytes_due
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } dec_byte_t;

    dec_byte_t          expected_bytes[$];
    dec_byte_t          want;
    logic [7:0]         hist_mem [HISTORY_DEPTH];
    phase_t             phase;
    logic [2:0]         hdr_left;
    logic [1:0]         hdr_seen;
    logic [ALU_W-1:0]   lit_left;
    logic [LEN_W-1:0]   copy_len;
    logic [ACC_W-1:0]   acc;
    logic [HIST_AW-1:0] wr_ptr;
    logic [HELD_W-1:0]  held;

    // Expected results leave in the order they are queued here.
    function void queue_expected(input dec_byte_t r);
        expected_bytes.insert(expected_bytes.size(), r);
    endfunction

    function void clear_parser();
        phase    = PH_TAG;
        hdr_left = '0;
        hdr_seen = '0;
        lit_left = '0;
        copy_len = '0;
        acc      = '0;
        wr_ptr   = '0;
        held     = '0;
    endfunction

    function void record(input logic [7:0] b);
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (held < HISTORY_DEPTH)
            held = held + 1'b1;
    endfunction

    // Length and offset fields arrive least significant byte first.
    function void take_field_byte(input logic [7:0] b);
        acc      = acc | (ACC_W'(b) << (8 * hdr_seen));
        hdr_seen = hdr_seen + 1'b1;
        hdr_left = hdr_left - 1'b1;
    endfunction

    // An offset shorter than the length reads bytes written earlier in the same
    // copy, which repeats the pattern.
    function void replay_copy();
        logic [HIST_AW-1:0] src;
        logic [7:0]         b;
        phase = PH_TAG;
        if (acc == 0 || acc > held)
        begin
            queue_expected(dec_byte_t'({8'h00, 1'b1, 1'b1}));
            return;
        end
        for (int i = 0; i < copy_len; i++)
        begin
            src = wr_ptr - HIST_AW'(acc);
            b   = hist_mem[src];
            record(b);
            queue_expected(dec_byte_t'({b, i == copy_len - 1, 1'b0}));
        end
    endfunction

    function void decode_tag(input logic [7:0] b);
        logic [5:0] val;
        val      = b[7:2];
        acc      = '0;
        hdr_seen = '0;
        case (elem_t'(b[1:0]))
            ELEM_LITERAL:
            begin
                if (val < LIT_INLINE_MAX)
                begin
                    lit_left = ALU_W'(val) + 1'b1;
                    phase    = PH_LITDATA;
                end
                else
                begin
                    hdr_left = 3'(val - LIT_HDR_BIAS);
                    phase    = PH_LITLEN;
                end
            end
            ELEM_COPY1:
            begin
                copy_len = LEN_W'(val[2:0]) + LEN_W'(COPY1_BASE);
                acc      = ACC_W'({b[7:5], 8'h00});
                hdr_left = 3'd1;
                phase    = PH_COPYOFF;
            end
            ELEM_COPY2:
            begin
                copy_len = LEN_W'(val) + 1'b1;
                hdr_left = 3'(COPY2_OFF_LEN);
                phase    = PH_COPYOFF;
            end
            default:
            begin
                copy_len = LEN_W'(val) + 1'b1;
                hdr_left = 3'(COPY4_OFF_LEN);
                phase    = PH_COPYOFF;
            end
        endcase
    endfunction

    function void decode_byte(input logic [7:0] b, input logic start);
        if (start)
            clear_parser();
        case (phase)
            PH_LITLEN:
            begin
                take_field_byte(b);
                if (hdr_left == 0)
                begin
                    lit_left = ALU_W'(acc) + 1'b1;
                    phase    = PH_LITDATA;
                end
            end
            PH_LITDATA:
            begin
                record(b);
                lit_left = lit_left - 1'b1;
                if (lit_left == 0)
                    phase = PH_TAG;
                queue_expected(dec_byte_t'({b, 1'b1, 1'b0}));
            end
            PH_COPYOFF:
            begin
                take_field_byte(b);
                if (hdr_left == 0)
                    replay_copy();
            end
            default:
                decode_tag(b);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_bytes.delete();
            fail_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected transfer: out_byte %h is_last %b error %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.data, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: is_last expected %b actual %b",
                                 $time, want.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.err)
                    begin
                        $display("%0t: error expected %b actual %b",
                                 $time, want.err, m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
        bytes_due = expected_bytes.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the Snappy block decompressor: clock, reset, compressed stream
// stimulus with sender gaps and receiver stalls, and the verdict.
// Depends on snbd_pkg, snappy_block_decompressor and snbd_decode_checker.
module tb;
    import snbd_pkg::*;

    localparam int COPY1_OFF_MAX = 2047;
    localparam int COPY2_OFF_MAX = 65535;
    localparam int RANDOM_ITEMS  = 85;
    localparam int TAIL_CYCLES   = 200;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic [0:0] s_axis_tuser  = 1'b0;    // [0] stream_start
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;            // [0] error

    int fail_count;
    int bytes_due;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int held_est       = 0;
    int items_sent     = 0;
    bit restart        = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    snappy_block_decompressor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    snbd_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .bytes_due     (bytes_due)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // The next byte sent opens a new stream, so no history is held yet.
    function void mark_restart();
        restart  = 1'b1;
        held_est = 0;
    endfunction

    function void grow_history(input int len);
        held_est = (held_est + len > HISTORY_DEPTH) ? HISTORY_DEPTH : held_est + len;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        restart = 1'b0;
        items_sent++;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // A header count of zero puts the length in the tag itself.
    task automatic send_literal(input int len, input int nhdr);
        if (nhdr == 0)
            put_byte({6'(len - 1), ELEM_LITERAL});
        else
        begin
            put_byte({6'(LIT_HDR_BIAS + nhdr), ELEM_LITERAL});
            for (int i = 0; i < nhdr; i++)
                put_byte(8'((len - 1) >> (8 * i)));
        end
        repeat (len)
            put_byte(8'($urandom));
        grow_history(len);
    endtask

    task automatic send_copy(input elem_t kind, input int len, input logic [31:0] off);
        case (kind)
            ELEM_COPY1:
            begin
                put_byte({3'(off >> 8), 3'(len - COPY1_BASE), ELEM_COPY1});
                put_byte(off[7:0]);
            end
            ELEM_COPY2:
            begin
                put_byte({6'(len - 1), ELEM_COPY2});
                for (int i = 0; i < COPY2_OFF_LEN; i++)
                    put_byte(8'(off >> (8 * i)));
            end
            default:
            begin
                put_byte({6'(len - 1), ELEM_COPY4});
                for (int i = 0; i < COPY4_OFF_LEN; i++)
                    put_byte(8'(off >> (8 * i)));
            end
        endcase
        if (off != 0 && off <= held_est)
            grow_history(len);
    endtask

    // Mostly well-formed elements against the history held so far, with some bad
    // offsets and some truncated elements cut short by a new stream.
    task automatic send_random_element();
        int    pick;
        int    len;
        int    off_max;
        int    r;
        elem_t kind;
        if ($urandom_range(99) < 8)
            mark_restart();
        pick = $urandom_range(99);
        kind = elem_t'($urandom_range(ELEM_COPY1, ELEM_COPY4));
        if (kind == ELEM_COPY1)
            len = $urandom_range(COPY1_BASE, COPY1_BASE + 7);
        else
            len = ($urandom_range(99) < 70) ? $urandom_range(1, 16) : $urandom_range(1, 64);
        if (pick < 30 || (pick < 80 && held_est == 0))
        begin
            r = $urandom_range(99);
            if (r < 80)
                len = $urandom_range(1, 8);
            else if (r < 95)
                len = $urandom_range(9, LIT_INLINE_MAX);
            else
                len = $urandom_range(LIT_INLINE_MAX + 1, 80);
            if (len > LIT_INLINE_MAX || $urandom_range(99) < 15)
                send_literal(len, $urandom_range(1, 4));
            else
                send_literal(len, 0);
        end
        else if (pick < 80)
        begin
            off_max = held_est;
            if (kind == ELEM_COPY1 && off_max > COPY1_OFF_MAX)
                off_max = COPY1_OFF_MAX;
            else if (kind == ELEM_COPY2 && off_max > COPY2_OFF_MAX)
                off_max = COPY2_OFF_MAX;
            if ($urandom_range(99) < 50)
                send_copy(kind, len, $urandom_range(1, (off_max < 8) ? off_max : 8));
            else
                send_copy(kind, len, $urandom_range(1, off_max));
        end
        else if (pick < 92)
        begin
            case ($urandom_range(2))
                0: send_copy(kind, len, 0);
                1:
                begin
                    if ((kind == ELEM_COPY1 && held_est + 1 > COPY1_OFF_MAX) ||
                        (kind == ELEM_COPY2 && held_est + 1 > COPY2_OFF_MAX))
                        kind = ELEM_COPY4;
                    send_copy(kind, len, held_est + 1);
                end
                default: send_copy(ELEM_COPY4, len, $urandom | 32'h0002_0000);
            endcase
        end
        else
        begin
            put_byte(8'($urandom));
            repeat ($urandom_range(3))
                put_byte(8'($urandom));
            mark_restart();
        end
    endtask

    initial
    begin
        int target;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: data extremes, short and four-byte literal headers, an
        // overlapping copy, offset zero, offset equal to and one beyond history.
        mark_restart();
        put_byte({6'd1, ELEM_LITERAL});
        put_byte(8'hFF);
        put_byte(8'h00);
        grow_history(2);
        send_literal(1, 1);
        send_literal(2, COPY4_OFF_LEN);
        send_copy(ELEM_COPY1, COPY1_BASE, 1);
        send_copy(ELEM_COPY1, COPY1_BASE + 7, 0);
        send_copy(ELEM_COPY2, 64, held_est);
        send_copy(ELEM_COPY4, 64, held_est + 1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 54;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 54;
                end
                default:
                begin
                    src_idle_pct   = 23;
                    sink_stall_pct = 23;
                end
            endcase
            target = items_sent + RANDOM_ITEMS;
            while (items_sent < target)
                send_random_element();
        end
        s_axis_tvalid <= 1'b0;

        @(negedge clk);
        while (bytes_due != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && bytes_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
